// ===== sv/pli_pkg.sv =====
// Shared types and constants for the positional list block.
`timescale 1ns / 1ps

package pli_pkg;

	localparam int DEPTH_DEF = 64;

	localparam int CMD_W    = 2;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 7;
	localparam int STATUS_W = 2;
	localparam int INDEX_W  = 6;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_DELETE = 2'd1,
		CMD_DUMP   = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK     = 2'd0,
		STAT_BADPOS = 2'd1,
		STAT_FULL   = 2'd2,
		STAT_EMPTY  = 2'd3
	} status_t;

endpackage

// ===== sv/positional_list_insert_delete_top.sv =====
// Positional list: insert, delete and dump over a one-read, one-write element memory.
`timescale 1ns / 1ps

// The list lives in a DEPTH-entry memory with one write and one registered read
// port, walked by a single pointer and its one increment/decrement adder. One
// item is in work at a time; in_stall is high from acceptance until the result
// register has been loaded. An insert moves each element from the position on
// up and a delete each element after it down, with one read and one write of
// the memory per element; a rejected command goes straight to the result. A
// dump emits count results, each one memory read and then the load of the
// result register, held back while the downstream side stalls. Storage is
// not cleared at reset; the count, state and valid flags are.
module positional_list_insert_delete_top #(
	parameter int DEPTH = pli_pkg::DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [pli_pkg::CMD_W-1:0]           cmd,
	input  logic signed [pli_pkg::VALUE_W-1:0]  value,
	input  logic [pli_pkg::POS_W-1:0]           position,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [pli_pkg::STATUS_W-1:0]        status,
	output logic signed [pli_pkg::VALUE_W-1:0]  element,
	output logic [pli_pkg::INDEX_W-1:0]         element_index,
	output logic                                last
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [8:0] {
		S_IDLE    = 9'b000000001,
		S_INS_RD  = 9'b000000010,
		S_INS_WR  = 9'b000000100,
		S_INS_PUT = 9'b000001000,
		S_DEL_RD  = 9'b000010000,
		S_DEL_WR  = 9'b000100000,
		S_DEL_FIN = 9'b001000000,
		S_DMP_RD  = 9'b010000000,
		S_RESP    = 9'b100000000
	} state_t;

	state_t state_q;

	logic [CW-1:0] count_q;
	logic [CW-1:0] ptr_q;
	logic [CW-1:0] pos_q;
	logic [CW-1:0] cnt_m1_q;
	logic [pli_pkg::VALUE_W-1:0] value_q;
	logic [pli_pkg::STATUS_W-1:0] resp_q;
	logic dmp_wait_q;

	logic out_valid_q;
	logic [pli_pkg::STATUS_W-1:0] out_status_q;
	logic [pli_pkg::VALUE_W-1:0] out_elem_q;
	logic [pli_pkg::INDEX_W-1:0] out_index_q;
	logic out_last_q;

	logic [pli_pkg::VALUE_W-1:0] mem [DEPTH];
	logic [pli_pkg::VALUE_W-1:0] rd_q;
	logic mem_we;
	logic [AW-1:0] mem_wa;
	logic [AW-1:0] mem_ra;
	logic [pli_pkg::VALUE_W-1:0] mem_wd;

	logic [CW-1:0] ptr_sum;
	logic [CW-1:0] cnt_m1;
	logic out_free;
	logic out_load;
	logic in_acc;

	assign in_acc   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = out_free && (state_q == S_RESP || (state_q == S_DMP_RD && dmp_wait_q));

	// The one pointer adder: steps down while shifting up for an insert,
	// up everywhere else.
	always_comb begin
		if (state_q == S_INS_RD || state_q == S_INS_WR) begin
			ptr_sum = ptr_q - CW'(1);
		end else begin
			ptr_sum = ptr_q + CW'(1);
		end
	end

	assign cnt_m1 = count_q - CW'(1);

	always_comb begin
		mem_we = 1'b0;
		mem_wa = ptr_q[AW-1:0];
		mem_wd = rd_q;
		mem_ra = ptr_q[AW-1:0];
		case (state_q)
			S_INS_RD: begin
				mem_ra = ptr_sum[AW-1:0];
			end
			S_INS_WR: begin
				mem_we = 1'b1;
			end
			S_INS_PUT: begin
				mem_we = 1'b1;
				mem_wa = pos_q[AW-1:0];
				mem_wd = value_q;
			end
			S_DEL_RD: begin
				mem_ra = ptr_sum[AW-1:0];
			end
			S_DEL_WR: begin
				mem_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			dmp_wait_q  <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						pos_q    <= CW'(position);
						ptr_q    <= CW'(position);
						value_q  <= value;
						cnt_m1_q <= cnt_m1;
						case (cmd)
							pli_pkg::CMD_INSERT: begin
								if (position > pli_pkg::POS_W'(count_q)) begin
									resp_q  <= pli_pkg::STAT_BADPOS;
									state_q <= S_RESP;
								end else if (count_q == CW'(DEPTH)) begin
									resp_q  <= pli_pkg::STAT_FULL;
									state_q <= S_RESP;
								end else begin
									ptr_q <= count_q;
									if (CW'(position) == count_q) begin
										state_q <= S_INS_PUT;
									end else begin
										state_q <= S_INS_RD;
									end
								end
							end
							pli_pkg::CMD_DELETE: begin
								if (position >= pli_pkg::POS_W'(count_q)) begin
									resp_q  <= pli_pkg::STAT_BADPOS;
									state_q <= S_RESP;
								end else if (CW'(position) == cnt_m1) begin
									state_q <= S_DEL_FIN;
								end else begin
									state_q <= S_DEL_RD;
								end
							end
							pli_pkg::CMD_DUMP: begin
								if (count_q == '0) begin
									resp_q  <= pli_pkg::STAT_EMPTY;
									state_q <= S_RESP;
								end else begin
									ptr_q      <= '0;
									dmp_wait_q <= 1'b0;
									state_q    <= S_DMP_RD;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_INS_RD: begin
					state_q <= S_INS_WR;
				end
				S_INS_WR: begin
					ptr_q <= ptr_sum;
					if (ptr_sum == pos_q) begin
						state_q <= S_INS_PUT;
					end else begin
						state_q <= S_INS_RD;
					end
				end
				S_INS_PUT: begin
					count_q <= count_q + CW'(1);
					resp_q  <= pli_pkg::STAT_OK;
					state_q <= S_RESP;
				end
				S_DEL_RD: begin
					state_q <= S_DEL_WR;
				end
				S_DEL_WR: begin
					ptr_q <= ptr_sum;
					if (ptr_sum == cnt_m1_q) begin
						state_q <= S_DEL_FIN;
					end else begin
						state_q <= S_DEL_RD;
					end
				end
				S_DEL_FIN: begin
					count_q <= cnt_m1_q;
					resp_q  <= pli_pkg::STAT_OK;
					state_q <= S_RESP;
				end
				S_DMP_RD: begin
					// The first cycle here issues the read; rd_q then holds the
					// element until the result register can take it.
					if (!dmp_wait_q) begin
						dmp_wait_q <= 1'b1;
					end else if (out_free) begin
						out_status_q <= pli_pkg::STAT_OK;
						out_elem_q   <= rd_q;
						out_index_q  <= pli_pkg::INDEX_W'(ptr_q);
						out_last_q   <= (ptr_q == cnt_m1_q);
						dmp_wait_q   <= 1'b0;
						if (ptr_q == cnt_m1_q) begin
							state_q <= S_IDLE;
						end else begin
							ptr_q <= ptr_sum;
						end
					end
				end
				S_RESP: begin
					if (out_free) begin
						out_status_q <= resp_q;
						out_elem_q   <= '0;
						out_index_q  <= '0;
						out_last_q   <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign element       = out_elem_q;
	assign element_index = out_index_q;
	assign last          = out_last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("element count exceeds the list depth");

	a_reject_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_status_q != pli_pkg::STAT_OK |->
			out_elem_q == '0 && out_index_q == '0 && out_last_q)
		else $error("non-ok result carries element data or is not last");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_INS_PUT |=> count_q == $past(count_q) + CW'(1))
		else $error("completed insert did not grow the count by one");

	a_dump_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_status_q == pli_pkg::STAT_OK && !out_last_q |->
			(pli_pkg::POS_W'(out_index_q) + pli_pkg::POS_W'(1)) < pli_pkg::POS_W'(count_q))
		else $error("dump item without last lies at or past the end of the list");

endmodule
